// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the text LCD controller.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define TLCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define TLCD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/tlcd_pkg.sv =====
// Package of the text LCD controller: payload types, command and byte codes,
// and the microcode program of the sequencer. No dependencies.
`timescale 1ns / 1ps

package tlcd_pkg;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_GOTO  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_INIT  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_code;
    logic [1:0] line;
    logic [4:0] column;
  } cmd_t;

  typedef struct packed {
    logic       send;
    logic       is_data;
    logic [7:0] lcd_byte;
    logic       error;
    logic       last;
  } res_t;

  typedef struct packed {
    logic append_mode;
  } cfg_t;

  localparam logic [7:0] LCD_CLS     = 8'h01;
  localparam logic [7:0] LCD_HOME    = 8'h80;
  localparam logic [7:0] LCD_LINE1   = 8'hC0;
  localparam logic [7:0] LCD_FUNC8   = 8'h33;
  localparam logic [7:0] LCD_FUNC4   = 8'h32;
  localparam logic [7:0] LCD_FUNC2L  = 8'h2C;
  localparam logic [7:0] LCD_DISPON  = 8'h0E;
  localparam logic [7:0] LCD_ENTRY   = 8'h06;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;

  // Source of the result byte of a step.
  typedef enum logic [2:0] {
    EM_NONE,
    EM_CONST,
    EM_CHAR,
    EM_GOTO,
    EM_CELL,
    EM_ERR
  } emit_e;

  // Datapath operation of a step.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE_CUR,
    OP_WRAP,
    OP_SET_CUR,
    OP_BLANK,
    OP_RING_WR,
    OP_RD_FIRST,
    OP_RD_NEXT
  } op_e;

  typedef enum logic {
    CND_ALWAYS,
    CND_ROW_BRK
  } cond_e;

  typedef logic [3:0] pc_t;

  localparam pc_t P_IDLE  = 4'd0;
  localparam pc_t P_PUT   = 4'd1;
  localparam pc_t P_ERR   = 4'd2;
  localparam pc_t P_WRAP  = 4'd3;
  localparam pc_t P_GOTO  = 4'd4;
  localparam pc_t P_CLR   = 4'd5;
  localparam pc_t P_INIT0 = 4'd6;
  localparam pc_t P_INIT1 = 4'd7;
  localparam pc_t P_INIT2 = 4'd8;
  localparam pc_t P_INIT3 = 4'd9;
  localparam pc_t P_INIT4 = 4'd10;
  localparam pc_t P_SCR0  = 4'd11;
  localparam pc_t P_SCR1  = 4'd12;
  localparam pc_t P_SCR2  = 4'd13;
  localparam pc_t P_SCR3  = 4'd14;

  typedef struct packed {
    emit_e      emit;
    logic [7:0] lit;
    op_e        op;
    cond_e      cond;
    logic       loop;
    pc_t        tgt;
    pc_t        alt;
  } ctrl_t;

  // Control store: jump to tgt when the condition holds, else to alt.
  // With loop set, the final cell of the buffer ends the program.
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    w = '{emit: EM_NONE, lit: 8'h00, op: OP_NONE, cond: CND_ALWAYS, loop: 1'b0,
          tgt: P_IDLE, alt: P_IDLE};
    case (pc)
      P_PUT:   w = '{EM_CHAR,  8'h00,      OP_WRITE_CUR, CND_ALWAYS,  1'b0, P_IDLE, P_IDLE};
      P_ERR:   w = '{EM_ERR,   8'h00,      OP_NONE,      CND_ALWAYS,  1'b0, P_IDLE, P_IDLE};
      P_WRAP:  w = '{EM_CONST, LCD_LINE1,  OP_WRAP,      CND_ALWAYS,  1'b0, P_PUT,  P_PUT};
      P_GOTO:  w = '{EM_GOTO,  8'h00,      OP_SET_CUR,   CND_ALWAYS,  1'b0, P_IDLE, P_IDLE};
      P_CLR:   w = '{EM_CONST, LCD_CLS,    OP_BLANK,     CND_ALWAYS,  1'b0, P_IDLE, P_IDLE};
      P_INIT0: w = '{EM_CONST, LCD_FUNC8,  OP_NONE,      CND_ALWAYS,  1'b0, P_INIT1, P_INIT1};
      P_INIT1: w = '{EM_CONST, LCD_FUNC4,  OP_NONE,      CND_ALWAYS,  1'b0, P_INIT2, P_INIT2};
      P_INIT2: w = '{EM_CONST, LCD_FUNC2L, OP_NONE,      CND_ALWAYS,  1'b0, P_INIT3, P_INIT3};
      P_INIT3: w = '{EM_CONST, LCD_DISPON, OP_NONE,      CND_ALWAYS,  1'b0, P_INIT4, P_INIT4};
      P_INIT4: w = '{EM_CONST, LCD_ENTRY,  OP_NONE,      CND_ALWAYS,  1'b0, P_CLR,  P_CLR};
      P_SCR0:  w = '{EM_CONST, LCD_CLS,    OP_RING_WR,   CND_ALWAYS,  1'b0, P_SCR1, P_SCR1};
      P_SCR1:  w = '{EM_CONST, LCD_HOME,   OP_RD_FIRST,  CND_ALWAYS,  1'b0, P_SCR2, P_SCR2};
      P_SCR2:  w = '{EM_CELL,  8'h00,      OP_RD_NEXT,   CND_ROW_BRK, 1'b1, P_SCR3, P_SCR2};
      P_SCR3:  w = '{EM_CONST, LCD_LINE1,  OP_NONE,      CND_ALWAYS,  1'b0, P_SCR2, P_SCR2};
      default: w = '{EM_NONE,  8'h00,      OP_NONE,      CND_ALWAYS,  1'b0, P_IDLE, P_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/tlcd_chan_if.sv =====
// Valid/ready channel carrying one payload item of type T.
// Depends on nothing; payload types come from tlcd_pkg at instantiation.
`timescale 1ns / 1ps

interface tlcd_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/text_lcd_append_scroll_controller.sv =====
// Character LCD controller: microcoded sequencer with shadow cell buffer; uses tlcd_pkg,
// tlcd_chan_if and assert_macros.svh. A command is taken only while idle; the program
// then emits registered items, one per cycle unless the sink stalls. Items: 1 (put,
// cursor, clear, error), 2 (wrap), 6 (init), 2 + COLUMNS*LINES + (LINES-1) for a scroll
// redraw, one control step each. Reset clears control state; every cell reads as a
// space via per-cell valid bits.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_lcd_append_scroll_controller #(
  parameter int COLUMNS = 16,
  parameter int LINES   = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tlcd_chan_if.sink    cmd_i,
  tlcd_chan_if.sink    cfg_i,
  tlcd_chan_if.source  res_o
);

  localparam int CELLS  = COLUMNS * LINES;
  localparam int CELL_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS + 1);

  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
  localparam logic [CELL_W-1:0] ROW_END   = CELL_W'(COLUMNS - 1);

  tlcd_pkg::pc_t            pc_q;
  tlcd_pkg::pc_t            pc_nx;
  tlcd_pkg::pc_t            entry;
  tlcd_pkg::ctrl_t          w;
  logic                     append_q;
  logic [7:0]               c_q;
  logic                     ln_q;
  logic [4:0]               colin_q;
  logic [COL_W-1:0]         col_q;
  logic                     line_q;
  logic [CELL_W-1:0]        ring_q;
  logic [CELL_W-1:0]        ring_inc;
  logic [CELL_W-1:0]        ptr_q;
  logic [CELL_W-1:0]        ptr_inc;
  logic [CELL_W-1:0]        cnt_q;
  logic [CELL_W-1:0]        cur_idx;
  logic [CELL_W-1:0]        wr_addr;
  logic                     wr_en;
  logic                     rd_en;
  logic [CELLS-1:0]         vld_q;
  logic [7:0]               mem_q [CELLS];
  logic [7:0]               mem_rd_q;
  logic                     rd_vld_q;
  logic                     step_en;
  logic                     cond_true;
  logic                     out_vld_q;
  tlcd_pkg::res_t           out_q;
  tlcd_pkg::res_t           res_nx;
  logic                     cmd_acc;
  logic                     seq_idle;
  logic                     ring_ok;
  logic                     cnt_ok;

  assign w         = tlcd_pkg::ucode(pc_q);
  assign step_en   = (pc_q != tlcd_pkg::P_IDLE) && (!out_vld_q || res_o.ready);
  assign cmd_i.ready = (pc_q == tlcd_pkg::P_IDLE);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

  assign ring_inc = (ring_q == LAST_CELL) ? '0 : ring_q + 1'b1;
  assign ptr_inc  = (ptr_q == LAST_CELL) ? '0 : ptr_q + 1'b1;
  assign cur_idx  = (line_q ? CELL_W'(COLUMNS) : '0) + CELL_W'(col_q);
  assign wr_addr  = (w.op == tlcd_pkg::OP_RING_WR) ? ring_inc : cur_idx;
  assign wr_en    = step_en &&
                    ((w.op == tlcd_pkg::OP_RING_WR) || (w.op == tlcd_pkg::OP_WRITE_CUR));
  assign rd_en    = step_en &&
                    ((w.op == tlcd_pkg::OP_RD_FIRST) || (w.op == tlcd_pkg::OP_RD_NEXT));

  // Dispatch on the accepted command.
  always_comb begin
    entry = tlcd_pkg::P_IDLE;
    case (cmd_i.data.command)
      tlcd_pkg::CMD_PUT: begin
        if ({1'b0, col_q} < (COL_W + 1)'(COLUMNS)) begin
          entry = tlcd_pkg::P_PUT;
        end else if (!append_q) begin
          entry = tlcd_pkg::P_ERR;
        end else if (!line_q && (LINES == 2)) begin
          entry = tlcd_pkg::P_WRAP;
        end else begin
          entry = tlcd_pkg::P_SCR0;
        end
      end
      tlcd_pkg::CMD_GOTO: begin
        if (({1'b0, cmd_i.data.line} < 3'(LINES)) &&
            ({1'b0, cmd_i.data.column} < 6'(COLUMNS))) begin
          entry = tlcd_pkg::P_GOTO;
        end else begin
          entry = tlcd_pkg::P_ERR;
        end
      end
      tlcd_pkg::CMD_CLEAR: entry = tlcd_pkg::P_CLR;
      tlcd_pkg::CMD_INIT:  entry = tlcd_pkg::P_INIT0;
      default:             entry = tlcd_pkg::P_ERR;
    endcase
  end

  always_comb begin
    case (w.cond)
      tlcd_pkg::CND_ALWAYS:  cond_true = 1'b1;
      tlcd_pkg::CND_ROW_BRK: cond_true = (cnt_q == ROW_END);
      default:               cond_true = 1'b1;
    endcase
    if (w.loop && (cnt_q == LAST_CELL)) begin
      pc_nx = tlcd_pkg::P_IDLE;
    end else begin
      pc_nx = cond_true ? w.tgt : w.alt;
    end
  end

  always_comb begin
    res_nx = '0;
    res_nx.last = (pc_nx == tlcd_pkg::P_IDLE);
    case (w.emit)
      tlcd_pkg::EM_CONST: begin
        res_nx.send     = 1'b1;
        res_nx.lcd_byte = w.lit;
      end
      tlcd_pkg::EM_CHAR: begin
        res_nx.send     = 1'b1;
        res_nx.is_data  = 1'b1;
        res_nx.lcd_byte = c_q;
      end
      tlcd_pkg::EM_GOTO: begin
        res_nx.send     = 1'b1;
        res_nx.lcd_byte = {1'b1, ln_q, 1'b0, colin_q};
      end
      tlcd_pkg::EM_CELL: begin
        res_nx.send     = 1'b1;
        res_nx.is_data  = 1'b1;
        res_nx.lcd_byte = rd_vld_q ? mem_rd_q : tlcd_pkg::CHAR_SPACE;
      end
      tlcd_pkg::EM_ERR:  res_nx.error = 1'b1;
      default:           res_nx = '0;
    endcase
  end

  // Sequencer and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= tlcd_pkg::P_IDLE;
      append_q  <= 1'b0;
      col_q     <= '0;
      line_q    <= 1'b0;
      ring_q    <= '0;
      ptr_q     <= '0;
      cnt_q     <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        append_q <= cfg_i.data.append_mode;
      end
      if (cmd_i.valid && cmd_i.ready) begin
        pc_q <= entry;
      end else if (step_en) begin
        pc_q <= pc_nx;
      end
      if (step_en) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (step_en) begin
        case (w.op)
          tlcd_pkg::OP_WRITE_CUR: begin
            ring_q <= cur_idx;
            col_q  <= col_q + 1'b1;
          end
          tlcd_pkg::OP_WRAP: begin
            line_q <= 1'b1;
            col_q  <= '0;
          end
          tlcd_pkg::OP_SET_CUR: begin
            line_q <= ln_q;
            col_q  <= COL_W'(colin_q);
          end
          tlcd_pkg::OP_BLANK: begin
            vld_q  <= '0;
            col_q  <= '0;
            line_q <= 1'b0;
            ring_q <= '0;
          end
          tlcd_pkg::OP_RING_WR: begin
            ring_q <= ring_inc;
            ptr_q  <= ring_inc;
          end
          tlcd_pkg::OP_RD_FIRST: begin
            ptr_q <= ptr_inc;
            cnt_q <= '0;
          end
          tlcd_pkg::OP_RD_NEXT: begin
            ptr_q <= ptr_inc;
            cnt_q <= cnt_q + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Command fields and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      c_q     <= cmd_i.data.char_code;
      ln_q    <= cmd_i.data.line[0];
      colin_q <= cmd_i.data.column;
    end
    if (step_en) begin
      out_q <= res_nx;
    end
  end

  // Cell buffer.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= c_q;
    end
    if (rd_en) begin
      mem_rd_q <= mem_q[ptr_inc];
      rd_vld_q <= vld_q[ptr_inc];
    end
  end

  assign cmd_acc  = cmd_i.valid && cmd_i.ready;
  assign seq_idle = (pc_q == tlcd_pkg::P_IDLE);
  assign ring_ok  = ({1'b0, ring_q} < (CELL_W + 1)'(CELLS));
  assign cnt_ok   = (pc_q != tlcd_pkg::P_SCR2) || ({1'b0, cnt_q} < (CELL_W + 1)'(CELLS));

  `TLCD_ASSERT(a_col_range, (col_q <= COL_W'(COLUMNS)), "cursor column past line end")
  `TLCD_ASSERT(a_ring_range, ring_ok, "ring index out of range")
  `TLCD_ASSERT(a_cnt_range, cnt_ok, "redraw count overrun")
  `TLCD_ASSERT_NEXT(a_last_idle, (step_en && res_nx.last), seq_idle, "last item left busy")
  `TLCD_ASSERT_NEXT(a_accept_busy, cmd_acc, !seq_idle, "command taken without a program")

endmodule
